>>> rtl/core/isa_pkg.sv
package isa_pkg;

  localparam int INDEX_W    = 5;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 5;
  localparam int STATUS_W   = 2;
  localparam int CAPACITY_D = 16;

  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the chain in the cycle of a transfer.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic               wr;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
  } cell_op_t;

endpackage

>>> rtl/core/isa_cell.sv
module isa_cell #(
  parameter int POS = 0
) (
  input  logic                        clk,
  input  isa_pkg::cell_op_t           op,
  input  logic [isa_pkg::VALUE_W-1:0] left,
  input  logic [isa_pkg::VALUE_W-1:0] right,
  output logic [isa_pkg::VALUE_W-1:0] word
);

  logic                        at_idx;
  logic                        above_idx;
  logic [isa_pkg::VALUE_W-1:0] word_next;

  assign at_idx    = (32'(op.index) == 32'(POS));
  assign above_idx = (32'(op.index) <  32'(POS));

  always_comb begin
    word_next = word;
    if (op.ins) begin
      if (above_idx) begin
        word_next = left;
      end else if (at_idx) begin
        word_next = op.value;
      end
    end else if (op.rem) begin
      // everything from the removed slot upward takes its upper neighbor
      if (above_idx || at_idx) begin
        word_next = right;
      end
    end else if (op.wr && at_idx) begin
      word_next = op.value;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

>>> rtl/core/indexed_shift_array_unit.sv
// A request accepted at one edge has its result registered and valid after that edge.
// Throughput: one request per cycle; every cell of the chain shifts or loads in parallel,
// and the single output register frees as soon as its result is taken.
// Reset (rst, synchronous): the store is empty and no result is pending;
// the cell words are not cleared and are never read before being written.
module indexed_shift_array_unit #(
  parameter int CAPACITY = isa_pkg::CAPACITY_D
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   mode,
  input  logic [isa_pkg::INDEX_W-1:0]  index,
  input  logic [isa_pkg::VALUE_W-1:0]  value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [isa_pkg::VALUE_W-1:0]  read_data,
  output logic [isa_pkg::COUNT_W-1:0]  count,
  output logic                         is_empty,
  output logic [isa_pkg::STATUS_W-1:0] status
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > isa_pkg::INDEX_W) ? CNT_W : isa_pkg::INDEX_W;

  logic [CNT_W-1:0]            live_count;
  logic [CNT_W-1:0]            live_count_next;
  logic [CMP_W-1:0]            idx_c;
  logic [CMP_W-1:0]            cnt_c;
  logic                        full;
  logic                        in_xfer;
  logic [ADDR_W-1:0]           rd_addr;
  isa_pkg::status_t            st_next;
  isa_pkg::cell_op_t           op;
  logic [isa_pkg::VALUE_W-1:0] rdata_next;
  logic [isa_pkg::VALUE_W-1:0] words [CAPACITY];

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign idx_c    = CMP_W'(index);
  assign cnt_c    = CMP_W'(live_count);
  assign full     = (live_count == CNT_W'(CAPACITY));
  assign rd_addr  = ADDR_W'(index);

  always_comb begin
    st_next         = isa_pkg::ST_OK;
    live_count_next = live_count;
    rdata_next      = '0;
    op.ins          = 1'b0;
    op.rem          = 1'b0;
    op.wr           = 1'b0;
    op.index        = index;
    op.value        = value;
    unique case (isa_pkg::mode_t'(mode))
      isa_pkg::MODE_INSERT: begin
        if (idx_c > cnt_c) begin
          st_next = isa_pkg::ST_RANGE;
        end else if (full) begin
          st_next = isa_pkg::ST_FULL;
        end else begin
          op.ins          = in_xfer;
          live_count_next = live_count + CNT_W'(1);
        end
      end
      isa_pkg::MODE_READ: begin
        if (idx_c >= cnt_c) begin
          st_next = isa_pkg::ST_RANGE;
        end else begin
          rdata_next = words[rd_addr];
        end
      end
      isa_pkg::MODE_WRITE: begin
        if (idx_c >= cnt_c) begin
          st_next = isa_pkg::ST_RANGE;
        end else begin
          op.wr = in_xfer;
        end
      end
      isa_pkg::MODE_REMOVE: begin
        if (idx_c >= cnt_c) begin
          st_next = isa_pkg::ST_RANGE;
        end else begin
          op.rem          = in_xfer;
          live_count_next = live_count - CNT_W'(1);
        end
      end
      default: st_next = isa_pkg::ST_RANGE;
    endcase
  end

  // The chain: each cell sees its lower and upper neighbor.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [isa_pkg::VALUE_W-1:0] left_w;
    logic [isa_pkg::VALUE_W-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = words[k];
    end else begin : g_mid_r
      assign right_w = words[k+1];
    end
    isa_cell #(.POS(k)) u_cell (
      .clk   (clk),
      .op    (op),
      .left  (left_w),
      .right (right_w),
      .word  (words[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (in_xfer) begin
        live_count <= live_count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      read_data <= rdata_next;
      count     <= isa_pkg::COUNT_W'(live_count_next);
      is_empty  <= (live_count_next == '0);
      status    <= st_next;
    end
  end

endmodule

>>> rtl/core/isa_checker.sv
module isa_checker #(
  parameter int CAPACITY = isa_pkg::CAPACITY_D
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [isa_pkg::VALUE_W-1:0]  read_data,
  input logic [isa_pkg::COUNT_W-1:0]  count,
  input logic                         is_empty,
  input logic [isa_pkg::STATUS_W-1:0] status
);

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != isa_pkg::ST_OK) |-> (read_data == '0))
    else $error("failed request returned data");

  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode != isa_pkg::MODE_READ) |=> out_valid && (read_data == '0))
    else $error("non-read request returned data or no result");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(count) <= 32'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind indexed_shift_array_unit isa_checker #(.CAPACITY(CAPACITY)) u_isa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .mode      (mode),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .read_data (read_data),
  .count     (count),
  .is_empty  (is_empty),
  .status    (status)
);

>>> bench/indexed_shift_array_unit_test.sv
`timescale 1ns / 100ps

module indexed_shift_array_unit_test;

  localparam int CAP        = isa_pkg::CAPACITY_D;
  localparam int NUM_RANDOM = 1550;
  localparam int IDLE_LIMIT = 4000;
  localparam int SHOW_MAX   = 10;

  typedef struct {
    isa_pkg::mode_t                m;
    logic [isa_pkg::INDEX_W-1:0]   idx;
    logic [isa_pkg::VALUE_W-1:0]   val;
    bit                            hold;  // wait for all results before this transfer
  } request_t;

  typedef struct {
    logic [isa_pkg::VALUE_W-1:0]   read_data;
    logic [isa_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;
    isa_pkg::status_t              status;
  } outcome_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [1:0]                     mode      = isa_pkg::MODE_READ;
  logic [isa_pkg::INDEX_W-1:0]    index     = '0;
  logic [isa_pkg::VALUE_W-1:0]    value     = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [isa_pkg::VALUE_W-1:0]    read_data;
  logic [isa_pkg::COUNT_W-1:0]    count;
  logic                           is_empty;
  logic [isa_pkg::STATUS_W-1:0]   status;

  request_t  request_q[$];
  outcome_t  outcome_q[$];

  // shadow of the store
  logic [isa_pkg::VALUE_W-1:0]  words[CAP];
  int                           word_count = 0;

  int errors     = 0;
  int gen_count  = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int idle_run   = 0;
  int cyc        = 0;
  int ready_mode = 0;

  indexed_shift_array_unit #(.CAPACITY(CAP)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .index     (index),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .count     (count),
    .is_empty  (is_empty),
    .status    (status)
  );

  always #5 clk = ~clk;

  function automatic outcome_t apply_request(isa_pkg::mode_t m,
                                             logic [isa_pkg::INDEX_W-1:0] idx,
                                             logic [isa_pkg::VALUE_W-1:0] val);
    outcome_t r;
    int       pos;
    r.read_data = '0;
    r.status    = isa_pkg::ST_OK;
    pos         = idx;
    if (m == isa_pkg::MODE_INSERT) begin
      if (pos > word_count) begin
        r.status = isa_pkg::ST_RANGE;
      end else if (word_count >= CAP) begin
        r.status = isa_pkg::ST_FULL;
      end else begin
        for (int k = word_count; k > pos; k--) words[k] = words[k-1];
        words[pos] = val;
        word_count++;
      end
    end else if (pos >= word_count || pos >= CAP) begin
      r.status = isa_pkg::ST_RANGE;
    end else if (m == isa_pkg::MODE_READ) begin
      r.read_data = words[pos];
    end else if (m == isa_pkg::MODE_WRITE) begin
      words[pos] = val;
    end else begin
      for (int k = pos; k + 1 < word_count; k++) words[k] = words[k+1];
      word_count--;
    end
    r.count    = word_count[isa_pkg::COUNT_W-1:0];
    r.is_empty = (word_count == 0);
    return r;
  endfunction

  // queue a request and follow the count it leaves, to steer the random mix
  task automatic queue_request(isa_pkg::mode_t m, int idx,
                               logic [isa_pkg::VALUE_W-1:0] val, bit hold = 0);
    request_t q;
    q.m    = m;
    q.idx  = idx[isa_pkg::INDEX_W-1:0];
    q.val  = val;
    q.hold = hold;
    request_q.push_back(q);
    if (m == isa_pkg::MODE_INSERT && idx <= gen_count && gen_count < CAP) gen_count++;
    else if (m == isa_pkg::MODE_REMOVE && idx < gen_count) gen_count--;
  endtask

  // driver
  always @(posedge clk) begin
    request_t nxt;
    bit       send;
    send = 0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        outcome_q.push_back(apply_request(isa_pkg::mode_t'(mode), index, value));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0 && (!request_q[0].hold || outcome_q.size() == 0)) begin
          nxt  = request_q.pop_front();
          send = 1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        if (send) begin
          in_valid <= 1'b1;
          mode     <= nxt.m;
          index    <= nxt.idx;
          value    <= nxt.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    outcome_t want;
    bit       rdy;
    cyc++;
    if (cyc % 128 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: rdy = 1'b1;
      1: rdy = $urandom_range(0, 1);
      2: rdy = ($urandom_range(0, 3) == 0);
      default: rdy = (cyc % 8) < 5;
    endcase
    if (!rst && out_valid && out_ready) begin
      if (outcome_q.size() == 0) begin
        if (errors < SHOW_MAX)
          $display("unexpected result: data=%h count=%0d empty=%0d status=%0d",
                   read_data, count, is_empty, status);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (read_data !== want.read_data || count !== want.count ||
            is_empty !== want.is_empty || status !== want.status) begin
          if (errors < SHOW_MAX)
            $display("mismatch: expected %s, got %s",
                     $sformatf("data=%h count=%0d empty=%0d status=%0d",
                               want.read_data, want.count, want.is_empty, want.status),
                     $sformatf("data=%h count=%0d empty=%0d status=%0d",
                               read_data, count, is_empty, status));
          errors++;
        end
      end
    end
    out_ready <= rdy;
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= IDLE_LIMIT) begin
        $display("indexed_shift_array_unit_test failed");
        $finish;
      end
    end
  end

  initial begin
    bit fill;
    int r;
    int idx;
    logic [isa_pkg::VALUE_W-1:0] val;
    isa_pkg::mode_t m;

    // empty store: every access is out of range; then inserts, and accesses in and out of range
    queue_request(isa_pkg::MODE_READ,   0, 32'h0);
    queue_request(isa_pkg::MODE_REMOVE, 0, 32'h0);
    queue_request(isa_pkg::MODE_WRITE,  0, 32'h1234_5678);
    queue_request(isa_pkg::MODE_INSERT, 1, 32'h0);
    queue_request(isa_pkg::MODE_INSERT, 0, 32'h8000_0000);
    queue_request(isa_pkg::MODE_INSERT, 1, 32'h7FFF_FFFF);
    queue_request(isa_pkg::MODE_INSERT, 0, 32'hFFFF_FFFF);
    queue_request(isa_pkg::MODE_READ,   0, 32'h0);
    queue_request(isa_pkg::MODE_READ,   2, 32'h0);
    queue_request(isa_pkg::MODE_READ,   3, 32'h0);
    queue_request(isa_pkg::MODE_WRITE,  1, 32'h0);
    queue_request(isa_pkg::MODE_WRITE,  31, 32'hFFFF_FFFF);
    queue_request(isa_pkg::MODE_REMOVE, 1, 32'h0);
    queue_request(isa_pkg::MODE_READ,   1, 32'h0);
    queue_request(isa_pkg::MODE_INSERT, 31, 32'h5555_5555);
    // fill to capacity at alternating ends
    while (gen_count < CAP)
      queue_request(isa_pkg::MODE_INSERT, (gen_count % 2) ? gen_count : 0, $urandom());
    queue_request(isa_pkg::MODE_INSERT, 5, 32'hAAAA_AAAA);   // full
    queue_request(isa_pkg::MODE_INSERT, 17, 32'hAAAA_AAAA);  // full and out of range
    queue_request(isa_pkg::MODE_READ,   15, 32'h0);
    queue_request(isa_pkg::MODE_READ,   16, 32'h0);
    queue_request(isa_pkg::MODE_REMOVE, 15, 32'h0, 1);
    queue_request(isa_pkg::MODE_REMOVE, 0, 32'h0);

    fill = 0;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (fill && gen_count == CAP && $urandom_range(0, 3) == 0) fill = 0;
      if (!fill && gen_count == 0 && $urandom_range(0, 3) == 0) fill = 1;
      r = $urandom_range(0, 99);
      if (r < 45)      m = fill ? isa_pkg::MODE_INSERT : isa_pkg::MODE_REMOVE;
      else if (r < 65) m = isa_pkg::MODE_READ;
      else if (r < 80) m = isa_pkg::MODE_WRITE;
      else             m = fill ? isa_pkg::MODE_REMOVE : isa_pkg::MODE_INSERT;
      if ($urandom_range(0, 9) < 8) begin
        if (m == isa_pkg::MODE_INSERT) idx = $urandom_range(0, gen_count);
        else idx = (gen_count > 0) ? $urandom_range(0, gen_count - 1) : 0;
      end else begin
        idx = $urandom_range(0, 31);
      end
      case ($urandom_range(0, 19))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom();
      endcase
      queue_request(m, idx, val, (i % 300) == 299);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() > 0 || in_valid || outcome_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("indexed_shift_array_unit_test passed");
    end else begin
      $display("indexed_shift_array_unit_test failed");
    end
    $finish;
  end

endmodule
